// ===== hw/rtl/rcpb_pkg.sv =====
package rcpb_pkg;

  localparam int unsigned MAX_LINES  = 32768;
  localparam int unsigned IDX_W      = $clog2(MAX_LINES);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned LINE_SHIFT = 6;
  localparam int unsigned RNG_W      = 64;
  localparam int unsigned BIT_CNT_W  = $clog2(RNG_W);
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned PADDR_W    = 4;

  localparam logic [RNG_W-1:0] SEED_C = 64'h9e3779b97f4a7c15;
  localparam logic [CFG_W-1:0] LINE_COUNT_RST = 16'd512;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT_WR,
    OP_SEED,
    OP_RNG,
    OP_DIV,
    OP_RD_I,
    OP_RD_J,
    OP_WR_I,
    OP_WR_J,
    OP_S_RD0,
    OP_S_FIRST,
    OP_S_RD,
    OP_S_WR,
    OP_S_CLOSE,
    OP_Q_RD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic i_last;
    logic n_one;
    logic div_last;
    logic i_one;
  } dp_stat_t;

endpackage

// ===== hw/rtl/random_cyclic_permutation_builder.sv =====
// Random cyclic permutation builder.
// Requests arrive on the input channel (in_valid_i, in_stall_o, req_type_i,
// line_index_i) and each one yields exactly one transaction on the output
// channel (out_valid_o, out_stall_i and the four result fields).
// A build request fills an order memory with the identity over n lines, then
// shuffles it with a xorshift64 generator and a bit-serial modulo unit, and
// finally writes a successor memory that links the lines into one cycle.
// In a build the modulo unit retires one dividend bit per cycle, 64 per swap,
// and each swap then works on the order memory in the steps read at i, read
// at j, write at i and write at j. A query reads the successor memory through
// a registered read and loads the result into the output register.
// One request is worked on at a time; in_stall_o is high while it runs.
// A finished result sits in the output register while the next request is
// already taken; the block holds a further result until the receiver drops
// out_stall_i, and the payload stays stable while stalled.
// Reset clears the control state, the generator and the built flag; the
// memories hold no defined value until a build writes them, and queries before
// the first build return line 0. The user must write registers over the APB
// port (line_count at 0, base_address at 8) only while idle; not enforced.
module random_cyclic_permutation_builder
  import rcpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [IDX_W-1:0]    line_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IDX_W-1:0]    next_line_o,
  output logic [ADDR_W-1:0]   next_address_o,
  output logic [ADDR_W-1:0]   start_address_o,
  output logic                ready_res_o
);

  logic [CFG_W-1:0]  line_count_q;
  logic [ADDR_W-1:0] base_q;
  logic              out_valid_q;
  logic [IDX_W-1:0]  next_line_q;
  logic [ADDR_W-1:0] next_addr_q, start_addr_q;
  logic              ready_q;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             out_free;
  logic [IDX_W-1:0] dp_next, dp_start;
  logic             dp_built;

  assign pready   = 1'b1;
  assign prdata   = paddr[3] ? DATA_W'(base_q) : DATA_W'(line_count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= LINE_COUNT_RST;
      base_q       <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        base_q <= pwdata[ADDR_W-1:0];
      end else begin
        line_count_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  rcpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rcpb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_type_i),
    .line_index_i (line_index_i),
    .line_count_i (line_count_q),
    .stat_o       (stat),
    .next_line_o  (dp_next),
    .start_line_o (dp_start),
    .built_o      (dp_built)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      next_line_q  <= dp_next;
      next_addr_q  <= base_q + (ADDR_W'(dp_next) << LINE_SHIFT);
      start_addr_q <= base_q + (ADDR_W'(dp_start) << LINE_SHIFT);
      ready_q      <= dp_built;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_line_o     = next_line_q;
  assign next_address_o  = next_addr_q;
  assign start_address_o = start_addr_q;
  assign ready_res_o     = ready_q;

endmodule

// ===== hw/rtl/rcpb_dp.sv =====
module rcpb_dp
  import rcpb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic             req_type_i,
  input  logic [IDX_W-1:0] line_index_i,
  input  logic [CFG_W-1:0] line_count_i,
  output dp_stat_t         stat_o,
  output logic [IDX_W-1:0] next_line_o,
  output logic [IDX_W-1:0] start_line_o,
  output logic             built_o
);

  logic [IDX_W-1:0] order_mem [MAX_LINES];
  logic [IDX_W-1:0] succ_mem  [MAX_LINES];

  logic [CNT_W-1:0]     n_q, i_q, built_n_q;
  logic [RNG_W-1:0]     rng_q, div_q;
  logic [CNT_W-1:0]     rem_q;
  logic [BIT_CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0]     j_q, oi_q, first_q, prev_q, start_q, qidx_q;
  logic [IDX_W-1:0]     ord_rd_q, suc_rd_q;
  logic                 built_q, query_q, hit_q;

  logic [CNT_W-1:0]   eff_n;
  logic [RNG_W-1:0]   rng_a, rng_b, rng_c;
  logic [CNT_W:0]     trial, dvs;
  logic [CNT_W-1:0]   rem_d;
  logic               ord_we, ord_re, suc_we;
  logic [IDX_W-1:0]   ord_waddr, ord_wdata, ord_raddr, suc_waddr, suc_wdata;

  always_comb begin
    if (line_count_i == '0) begin
      eff_n = CNT_W'(1);
    end else if (32'(line_count_i) > MAX_LINES) begin
      eff_n = CNT_W'(MAX_LINES);
    end else begin
      eff_n = CNT_W'(line_count_i);
    end
  end

  assign rng_a = rng_q ^ (rng_q << 13);
  assign rng_b = rng_a ^ (rng_a >> 7);
  assign rng_c = rng_b ^ (rng_b << 17);

  assign trial = {rem_q, div_q[RNG_W-1]};
  assign dvs   = {1'b0, i_q} + (CNT_W+1)'(1);
  assign rem_d = (trial >= dvs) ? CNT_W'(trial - dvs) : CNT_W'(trial);

  always_comb begin
    ord_we    = 1'b0;
    ord_re    = 1'b0;
    ord_waddr = i_q[IDX_W-1:0];
    ord_wdata = i_q[IDX_W-1:0];
    ord_raddr = i_q[IDX_W-1:0];
    suc_we    = 1'b0;
    suc_waddr = prev_q;
    suc_wdata = ord_rd_q;
    case (cmd_i.op)
      OP_INIT_WR: ord_we = 1'b1;
      OP_RD_I:    ord_re = 1'b1;
      OP_RD_J: begin
        ord_re    = 1'b1;
        ord_raddr = rem_q[IDX_W-1:0];
      end
      OP_WR_I: begin
        ord_we    = 1'b1;
        ord_wdata = ord_rd_q;
      end
      OP_WR_J: begin
        ord_we    = 1'b1;
        ord_waddr = j_q;
        ord_wdata = oi_q;
      end
      OP_S_RD0: begin
        ord_re    = 1'b1;
        ord_raddr = '0;
      end
      OP_S_RD:    ord_re = 1'b1;
      OP_S_WR:    suc_we = 1'b1;
      OP_S_CLOSE: begin
        suc_we    = 1'b1;
        suc_wdata = first_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rd_q <= order_mem[ord_raddr];
    end
    if (suc_we) begin
      succ_mem[suc_waddr] <= suc_wdata;
    end
    if (cmd_i.op == OP_Q_RD) begin
      suc_rd_q <= succ_mem[qidx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      i_q       <= '0;
      built_n_q <= '0;
      rng_q     <= '0;
      div_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      j_q       <= '0;
      oi_q      <= '0;
      first_q   <= '0;
      prev_q    <= '0;
      start_q   <= '0;
      qidx_q    <= '0;
      built_q   <= 1'b0;
      query_q   <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_ACCEPT: begin
          n_q     <= eff_n;
          i_q     <= '0;
          query_q <= req_type_i;
          qidx_q  <= line_index_i;
          hit_q   <= 1'b0;
        end
        OP_INIT_WR: i_q <= i_q + CNT_W'(1);
        OP_SEED: begin
          rng_q <= SEED_C ^ (RNG_W'(n_q) << LINE_SHIFT);
          i_q   <= n_q - CNT_W'(1);
        end
        OP_RNG: begin
          rng_q <= rng_c;
          div_q <= rng_c;
          rem_q <= '0;
          cnt_q <= '0;
        end
        OP_DIV: begin
          rem_q <= rem_d;
          div_q <= {div_q[RNG_W-2:0], 1'b0};
          cnt_q <= cnt_q + BIT_CNT_W'(1);
        end
        OP_RD_J: begin
          j_q  <= rem_q[IDX_W-1:0];
          oi_q <= ord_rd_q;
        end
        OP_WR_J:    i_q <= i_q - CNT_W'(1);
        OP_S_RD0:   i_q <= CNT_W'(1);
        OP_S_FIRST: begin
          first_q <= ord_rd_q;
          prev_q  <= ord_rd_q;
        end
        OP_S_WR: begin
          prev_q <= ord_rd_q;
          i_q    <= i_q + CNT_W'(1);
        end
        OP_S_CLOSE: begin
          start_q   <= first_q;
          built_n_q <= n_q;
          built_q   <= 1'b1;
        end
        OP_Q_RD:    hit_q <= built_q && ({1'b0, qidx_q} < built_n_q);
        default: ;
      endcase
    end
  end

  assign stat_o.is_query = query_q;
  assign stat_o.i_last   = (i_q == n_q - CNT_W'(1));
  assign stat_o.n_one    = (n_q == CNT_W'(1));
  assign stat_o.div_last = &cnt_q;
  assign stat_o.i_one    = (i_q == CNT_W'(1));

  assign next_line_o  = hit_q ? suc_rd_q : '0;
  assign start_line_o = start_q;
  assign built_o      = built_q;

endmodule

// ===== hw/rtl/rcpb_ctrl.sv =====
module rcpb_ctrl
  import rcpb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_free_i,
  input  dp_stat_t stat_i,
  output logic     in_stall_o,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_SEED, ST_RNG, ST_DIV, ST_RDI, ST_RDJ, ST_WRI, ST_WRJ,
    ST_SRD0, ST_SFIRST, ST_SRD, ST_SWR, ST_SCLOSE, ST_QRD, ST_DONE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_QRD;
        ST_INIT:   if (stat_i.i_last) state_q <= ST_SEED;
        ST_SEED:   state_q <= stat_i.n_one ? ST_SRD0 : ST_RNG;
        ST_RNG:    state_q <= ST_DIV;
        ST_DIV:    if (stat_i.div_last) state_q <= ST_RDI;
        ST_RDI:    state_q <= ST_RDJ;
        ST_RDJ:    state_q <= ST_WRI;
        ST_WRI:    state_q <= ST_WRJ;
        ST_WRJ:    state_q <= stat_i.i_one ? ST_SRD0 : ST_RNG;
        ST_SRD0:   state_q <= ST_SFIRST;
        ST_SFIRST: state_q <= stat_i.n_one ? ST_SCLOSE : ST_SRD;
        ST_SRD:    state_q <= ST_SWR;
        ST_SWR:    state_q <= stat_i.i_last ? ST_SCLOSE : ST_SRD;
        ST_SCLOSE: state_q <= ST_DONE;
        ST_QRD:    state_q <= stat_i.is_query ? ST_DONE : ST_INIT;
        ST_DONE:   if (out_free_i) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.load_out = 1'b0;
    in_stall_o     = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:   if (in_valid_i) cmd_o.op = OP_ACCEPT;
      ST_INIT:   cmd_o.op = OP_INIT_WR;
      ST_SEED:   cmd_o.op = OP_SEED;
      ST_RNG:    cmd_o.op = OP_RNG;
      ST_DIV:    cmd_o.op = OP_DIV;
      ST_RDI:    cmd_o.op = OP_RD_I;
      ST_RDJ:    cmd_o.op = OP_RD_J;
      ST_WRI:    cmd_o.op = OP_WR_I;
      ST_WRJ:    cmd_o.op = OP_WR_J;
      ST_SRD0:   cmd_o.op = OP_S_RD0;
      ST_SFIRST: cmd_o.op = OP_S_FIRST;
      ST_SRD:    cmd_o.op = OP_S_RD;
      ST_SWR:    cmd_o.op = OP_S_WR;
      ST_SCLOSE: cmd_o.op = OP_S_CLOSE;
      ST_QRD:    if (stat_i.is_query) cmd_o.op = OP_Q_RD;
      ST_DONE:   cmd_o.load_out = out_free_i;
      default: ;
    endcase
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import rcpb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 8_000_000;
  localparam int unsigned IDLE_CYCLES    = 20;
  localparam int unsigned REG_LINE_COUNT = 0;
  localparam int unsigned REG_BASE_ADDR  = 1;
  localparam logic        REQ_BUILD      = 1'b0;
  localparam logic        REQ_QUERY      = 1'b1;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  typedef struct {
    logic             req_type;
    logic [IDX_W-1:0] line_index;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0]  next_line;
    logic [ADDR_W-1:0] next_address;
    logic [ADDR_W-1:0] start_address;
    logic              ready_res;
  } chase_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                req_type_i = 1'b0;
  logic [IDX_W-1:0]    line_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [IDX_W-1:0]    next_line_o;
  logic [ADDR_W-1:0]   next_address_o;
  logic [ADDR_W-1:0]   start_address_o;
  logic                ready_res_o;

  request_t      pending_reqs[$];
  chase_result_t expected_results[$];

  logic [IDX_W-1:0]  order_mem[MAX_LINES];
  logic [IDX_W-1:0]  successor_mem[MAX_LINES];
  logic [IDX_W-1:0]  first_line = '0;
  logic              is_built = 1'b0;
  int unsigned       lines_built = 0;
  logic [CFG_W-1:0]  cur_line_count = LINE_COUNT_RST;
  logic [ADDR_W-1:0] cur_base = '0;

  int unsigned mismatches = 0;
  int unsigned idle_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned cycle_count = 0;

  random_cyclic_permutation_builder u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] line_address(logic [IDX_W-1:0] line);
    return cur_base + ({{(ADDR_W-IDX_W){1'b0}}, line} << LINE_SHIFT);
  endfunction

  function automatic void shuffle_lines();
    int unsigned n;
    int unsigned j;
    logic [63:0] x;
    logic [IDX_W-1:0] t;
    n = (cur_line_count == 0) ? 1 : int'(cur_line_count);
    if (n > MAX_LINES) n = MAX_LINES;
    for (int unsigned i = 0; i < n; i++) order_mem[i] = IDX_W'(i);
    x = SEED_C ^ (64'(n) << LINE_SHIFT);
    for (int unsigned i = n - 1; i > 0; i--) begin
      x ^= x << 13;
      x ^= x >> 7;
      x ^= x << 17;
      j = int'(x % (64'(i) + 64'd1));
      t = order_mem[i];
      order_mem[i] = order_mem[j];
      order_mem[j] = t;
    end
    for (int unsigned i = 0; i < n; i++)
      successor_mem[order_mem[i]] = order_mem[(i + 1 < n) ? i + 1 : 0];
    first_line = order_mem[0];
    lines_built = n;
    is_built = 1'b1;
  endfunction

  function automatic chase_result_t predict_chase(request_t r);
    chase_result_t res;
    res.next_line = '0;
    if (r.req_type == REQ_BUILD) shuffle_lines();
    else if (is_built && r.line_index < lines_built) res.next_line = successor_mem[r.line_index];
    res.next_address = line_address(res.next_line);
    res.start_address = line_address(first_line);
    res.ready_res = is_built;
    return res;
  endfunction

  always @(posedge clk_i) begin : driver
    request_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r.req_type = req_type_i;
        r.line_index = line_index_i;
        expected_results.push_back(predict_chase(r));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          req_type_i <= r.req_type;
          line_index_i <= r.line_index;
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin : monitor
    chase_result_t e;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected transaction", 64'd0, 64'(next_line_o));
        end else begin
          e = expected_results.pop_front();
          if (e.next_line !== next_line_o)
            report("next_line", 64'(e.next_line), 64'(next_line_o));
          if (e.next_address !== next_address_o)
            report("next_address", 64'(e.next_address), 64'(next_address_o));
          if (e.start_address !== start_address_o)
            report("start_address", 64'(e.start_address), 64'(start_address_o));
          if (e.ready_res !== ready_res_o)
            report("ready_res", 64'(e.ready_res), 64'(ready_res_o));
        end
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(int unsigned idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx * 8);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LINE_COUNT) cur_line_count = value[CFG_W-1:0];
    else if (idx == REG_BASE_ADDR) cur_base = value[ADDR_W-1:0];
  endtask

  task automatic push_req(logic kind, int unsigned idx);
    request_t r;
    r.req_type = kind;
    r.line_index = IDX_W'(idx);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned count, int unsigned max_lines);
    int unsigned n;
    n = $urandom_range(1, max_lines);
    write_reg(REG_LINE_COUNT, DATA_W'(n));
    write_reg(REG_BASE_ADDR, {$urandom, $urandom});
    if ($urandom_range(0, 1) == 0) push_req(REQ_BUILD, $urandom);
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: push_req(REQ_BUILD, $urandom);
        1, 2: push_req(REQ_QUERY, $urandom_range(0, 32767));
        default: push_req(REQ_QUERY, $urandom_range(0, n - 1));
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    push_req(REQ_QUERY, 0);
    push_req(REQ_QUERY, 32767);
    push_req(REQ_BUILD, 32767);
    push_req(REQ_QUERY, 0);
    push_req(REQ_QUERY, 511);
    push_req(REQ_QUERY, 512);
    push_req(REQ_QUERY, 32767);
    drain();
    write_reg(REG_LINE_COUNT, DATA_W'(0));
    write_reg(REG_BASE_ADDR, DATA_W'(ADDR_MAX));
    push_req(REQ_QUERY, 100);
    push_req(REQ_BUILD, 0);
    push_req(REQ_QUERY, 0);
    push_req(REQ_QUERY, 1);
    drain();
    write_reg(REG_LINE_COUNT, DATA_W'(2));
    push_req(REQ_BUILD, 0);
    push_req(REQ_QUERY, 0);
    push_req(REQ_QUERY, 1);
    push_req(REQ_QUERY, 2);
    drain();
    write_reg(REG_LINE_COUNT, DATA_W'(16'hFFFF));
    write_reg(REG_BASE_ADDR, {$urandom, $urandom});
    push_req(REQ_BUILD, 0);
    for (int k = 0; k < 200; k++) push_req(REQ_QUERY, $urandom_range(0, 32767));
    push_req(REQ_QUERY, 32767);
    drain();
    for (int p = 0; p < 10; p++) random_phase(120, (p % 3 == 0) ? 300 : 64);
    write_reg(REG_BASE_ADDR, DATA_W'(0));
    write_reg(REG_LINE_COUNT, DATA_W'(32768));
    for (int k = 0; k < 20; k++) push_req(REQ_QUERY, $urandom_range(0, 300));
    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
